### src/masked_sad_3x3_shift_sums_macros.svh
// assertion helpers for the top-level rtl file
`ifndef MASKED_SAD_3X3_SHIFT_SUMS_MACROS_SVH
`define MASKED_SAD_3X3_SHIFT_SUMS_MACROS_SVH

// same-cycle implication, checked out of reset
`define MSAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MSAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/msad_pkg.sv
package msad_pkg;

  localparam int PIX_W    = 8;
  localparam int SUM_W    = 32;
  localparam int OFFSETS  = 9;
  localparam int OFF_W    = 4;
  localparam int CFG_W    = 13;
  localparam int ROW_W    = 13;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MATCH_INDEX  = 2'd2,
    REG_MASK_ENABLE  = 2'd3
  } reg_idx_t;

  // control shared by every accumulator cell
  typedef struct packed {
    logic add_en;
    logic dump;
    logic shift;
  } cell_ctrl_t;

  // one line buffer word: two background rows, current row, match flag
  typedef struct packed {
    logic [PIX_W-1:0] bg_two;
    logic [PIX_W-1:0] bg_one;
    logic [PIX_W-1:0] cur_one;
    logic             match_one;
  } line_word_t;

endpackage

### src/msad_linebuf.sv
module msad_linebuf #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 25
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/msad_cell.sv
module msad_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msad_pkg::cell_ctrl_t          ctrl,
  input  logic [msad_pkg::PIX_W-1:0]    cur_pix,
  input  logic [msad_pkg::PIX_W-1:0]    bg_pix,
  input  logic [msad_pkg::SUM_W-1:0]    sum_in,
  output logic [msad_pkg::SUM_W-1:0]    sum_out
);

  logic [msad_pkg::SUM_W-1:0] acc_r;
  logic [msad_pkg::SUM_W-1:0] acc_nxt;
  logic [msad_pkg::SUM_W-1:0] out_r;
  logic [msad_pkg::PIX_W-1:0] diff;
  logic [msad_pkg::SUM_W:0]   wide_sum;

  // absolute difference and saturating add
  always_comb begin
    diff     = (cur_pix > bg_pix) ? (cur_pix - bg_pix) : (bg_pix - cur_pix);
    wide_sum = {1'b0, acc_r} + (msad_pkg::SUM_W + 1)'(diff);
    acc_nxt  = acc_r;
    if (ctrl.add_en) begin
      acc_nxt = wide_sum[msad_pkg::SUM_W] ? '1 : wide_sum[msad_pkg::SUM_W-1:0];
    end
  end

  // accumulator, cleared when the frame's sum is handed out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.dump) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // output stage of the drain chain
  always_ff @(posedge clk) begin
    if (ctrl.dump) begin
      out_r <= acc_nxt;
    end else if (ctrl.shift) begin
      out_r <= sum_in;
    end
  end

  assign sum_out = out_r;

endmodule

### src/masked_sad_3x3_shift_sums.sv
// Masked 3x3 shift sums of absolute differences.
// Input channel (in_valid/in_ready): one pixel triple per item, current,
// background and mask byte, in raster order, frame after frame.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
// frame width, frame height, match index or mask enable; write only idle.
// Output channel (out_valid/out_ready): nine items per frame, offset index
// 0..8 with its 32-bit saturated sum, last set on the ninth.
// Throughput: one input item per clock while in_ready is high. The line
// buffer is one memory with a registered read, so every item passes a read
// stage and then an accumulate stage. A frame's sums are latched into a drain
// chain through the nine accumulator cells in the cycle after its last pixel
// is taken, and the first sum is offered as soon as the sums are latched;
// the sums then leave one per clock while out_ready is high.
// The last pixel of a frame is held off (in_ready low) while the previous
// frame's sums still sit in the drain chain; with frames of eleven pixels
// or more and a receiver that keeps up this never happens.
// Reset clears position counters, accumulators and the drain count; the
// line buffers need no clearing since every entry used is first written.
`include "masked_sad_3x3_shift_sums_macros.svh"

module masked_sad_3x3_shift_sums #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [msad_pkg::PIX_W-1:0]         in_current_pixel,
  input  logic [msad_pkg::PIX_W-1:0]         in_background_pixel,
  input  logic [msad_pkg::PIX_W-1:0]         in_mask_pixel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [msad_pkg::OFF_W-1:0]         out_offset_index,
  output logic [msad_pkg::SUM_W-1:0]         out_sad_sum,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  msad_pkg::reg_idx_t                 cfg_index,
  input  logic [msad_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > msad_pkg::CFG_W) ? CW + 1 : msad_pkg::CFG_W + 1;
  localparam int HW = msad_pkg::ROW_W + 1;
  localparam int DW = $bits(msad_pkg::line_word_t);

  // configuration registers
  logic [msad_pkg::CFG_W-1:0] frame_width_r;
  logic [msad_pkg::CFG_W-1:0] frame_height_r;
  logic [msad_pkg::PIX_W-1:0] match_index_r;
  logic                       mask_enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= msad_pkg::CFG_W'(4096);
      frame_height_r <= msad_pkg::CFG_W'(4096);
      match_index_r  <= '0;
      mask_enable_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        msad_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        msad_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        msad_pkg::REG_MATCH_INDEX:  match_index_r  <= cfg_data[msad_pkg::PIX_W-1:0];
        msad_pkg::REG_MASK_ENABLE:  mask_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [EW-1:0] fw_ext;
  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    fw_ext = EW'(frame_width_r);
    if (fw_ext < EW'(3)) begin
      eff_w = EW'(3);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (frame_height_r < msad_pkg::CFG_W'(3)) ? HW'(3) : HW'(frame_height_r);
  end

  // raster position
  logic [CW-1:0]             col_r;
  logic [msad_pkg::ROW_W-1:0] row_r;
  logic                      row_end;
  logic                      frame_end;
  logic                      in_fire;
  logic                      match_now;

  assign row_end   = (EW'(col_r) + EW'(1)) >= eff_w;
  assign frame_end = row_end && ((HW'(row_r) + HW'(1)) >= eff_h);
  assign match_now = !mask_enable_r || (in_mask_pixel == match_index_r);

  // drain chain state
  logic [msad_pkg::OFF_W-1:0] out_cnt_r;
  logic                       s1_valid_r;
  logic                       s1_fe_r;

  // hold a frame's last pixel while the previous sums are still draining
  assign in_ready = !(frame_end && ((out_cnt_r != '0) || (s1_valid_r && s1_fe_r)));
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // read stage: item registers alongside the line buffer read
  logic [msad_pkg::PIX_W-1:0] s1_cur_r;
  logic [msad_pkg::PIX_W-1:0] s1_bg_r;
  logic                       s1_match_r;
  logic [CW-1:0]              s1_col_r;
  logic                       s1_inner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fe_r    <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s1_fe_r    <= in_fire && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r   <= in_current_pixel;
      s1_bg_r    <= in_background_pixel;
      s1_match_r <= match_now;
      s1_col_r   <= col_r;
      s1_inner_r <= (row_r >= msad_pkg::ROW_W'(2)) && (col_r >= CW'(2));
    end
  end

  // line buffer
  msad_pkg::line_word_t rd_word;
  msad_pkg::line_word_t wr_word;
  logic [DW-1:0]        rd_bits;

  assign rd_word = msad_pkg::line_word_t'(rd_bits);

  always_comb begin
    wr_word.bg_two    = rd_word.bg_one;
    wr_word.bg_one    = s1_bg_r;
    wr_word.cur_one   = s1_cur_r;
    wr_word.match_one = s1_match_r;
  end

  msad_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (DW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (rd_bits),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (DW'(wr_word))
  );

  // accumulate stage: window columns and the pixel one row above
  logic [msad_pkg::PIX_W-1:0] newcol     [3];
  logic [msad_pkg::PIX_W-1:0] win_near_r [3];
  logic [msad_pkg::PIX_W-1:0] win_far_r  [3];
  logic [msad_pkg::PIX_W-1:0] held_cur_r;
  logic                       held_match_r;

  assign newcol[0] = rd_word.bg_two;
  assign newcol[1] = rd_word.bg_one;
  assign newcol[2] = s1_bg_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_far_r[r]  <= win_near_r[r];
        win_near_r[r] <= newcol[r];
      end
      held_cur_r <= rd_word.cur_one;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_match_r <= 1'b0;
    end else if (s1_valid_r) begin
      held_match_r <= rd_word.match_one;
    end
  end

  // cell control
  msad_pkg::cell_ctrl_t ctrl;
  logic                 out_fire;

  assign out_valid = (out_cnt_r != '0);
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    ctrl.add_en = s1_valid_r && s1_inner_r && held_match_r;
    ctrl.dump   = s1_valid_r && s1_fe_r;
    ctrl.shift  = out_fire;
  end

  // row of accumulator cells, drained through cell 0
  logic [msad_pkg::SUM_W-1:0] sums [msad_pkg::OFFSETS+1];

  assign sums[msad_pkg::OFFSETS] = '0;

  for (genvar k = 0; k < msad_pkg::OFFSETS; k++) begin : g_cell
    logic [msad_pkg::PIX_W-1:0] tap;
    if (k % 3 == 0) begin : g_far
      assign tap = win_far_r[k / 3];
    end else if (k % 3 == 1) begin : g_near
      assign tap = win_near_r[k / 3];
    end else begin : g_new
      assign tap = newcol[k / 3];
    end

    msad_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .cur_pix (held_cur_r),
      .bg_pix  (tap),
      .sum_in  (sums[k+1]),
      .sum_out (sums[k])
    );
  end

  // count of sums left in the drain chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cnt_r <= '0;
    end else if (ctrl.dump) begin
      out_cnt_r <= msad_pkg::OFF_W'(msad_pkg::OFFSETS);
    end else if (out_fire) begin
      out_cnt_r <= out_cnt_r - 1'b1;
    end
  end

  assign out_offset_index = msad_pkg::OFF_W'(msad_pkg::OFFSETS) - out_cnt_r;
  assign out_sad_sum      = sums[0];
  assign out_last         = (out_cnt_r == msad_pkg::OFF_W'(1));

  // checks
  `MSAD_ASSERT_NOW(a_dump_empty, ctrl.dump, out_cnt_r == '0,
    "sums latched while drain chain busy")
  `MSAD_ASSERT_NEXT(a_dump_full, ctrl.dump, out_cnt_r == msad_pkg::OFF_W'(msad_pkg::OFFSETS),
    "drain count not loaded after frame end")
  `MSAD_ASSERT_NEXT(a_index_step, out_fire && !out_last,
    out_offset_index == $past(out_offset_index) + 1'b1,
    "offset index did not advance")
  `MSAD_ASSERT_NOW(a_stall_cause, !in_ready, frame_end,
    "input held off away from a frame end")

endmodule

### sim/masked_sad_3x3_shift_sums_checker.sv
module masked_sad_3x3_shift_sums_checker #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [msad_pkg::PIX_W-1:0] in_current_pixel,
  input  logic [msad_pkg::PIX_W-1:0] in_background_pixel,
  input  logic [msad_pkg::PIX_W-1:0] in_mask_pixel,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [msad_pkg::OFF_W-1:0] out_offset_index,
  input  logic [msad_pkg::SUM_W-1:0] out_sad_sum,
  input  logic                       out_last,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  msad_pkg::reg_idx_t         cfg_index,
  input  logic [msad_pkg::CFG_W-1:0] cfg_data,
  output int                         mismatch_count,
  output int                         sums_pending
);
  import msad_pkg::*;

  typedef struct {
    logic [OFF_W-1:0] offset;
    logic [SUM_W-1:0] sad;
    logic             last;
  } sad_result_t;

  sad_result_t expected_sums[$];

  // register copies
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [PIX_W-1:0] match_index;
  logic             mask_enable;

  // line buffers, window columns and raster position
  logic [PIX_W-1:0] bg_two_above [MAX_WIDTH];
  logic [PIX_W-1:0] bg_one_above [MAX_WIDTH];
  logic [PIX_W-1:0] cur_one_above [MAX_WIDTH];
  logic             match_one_above [MAX_WIDTH];
  logic [PIX_W-1:0] col_prev [3];
  logic [PIX_W-1:0] col_prev2 [3];
  logic [PIX_W-1:0] held_cur;
  logic             held_match;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [SUM_W-1:0] sad_acc [OFFSETS];
  int               errors = 0;

  // one pixel through the window; pushes nine sums on the frame's last pixel
  task automatic accumulate_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] bg,
                                  input logic [PIX_W-1:0] msk);
    int unsigned      eff_w;
    int unsigned      eff_h;
    int unsigned      col;
    logic [PIX_W-1:0] fresh [3];
    logic [PIX_W-1:0] ref_pix;
    logic [PIX_W-1:0] diff;
    logic [SUM_W:0]   total;
    logic             match_now;
    logic             row_end;
    logic             frame_end;
    sad_result_t      res;
    eff_w = (frame_width < 3) ? 3 : ((frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width);
    eff_h = (frame_height < 3) ? 3 : frame_height;
    col = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
    fresh[0] = bg_two_above[col];
    fresh[1] = bg_one_above[col];
    fresh[2] = bg;
    match_now = !mask_enable || (msk == match_index);

    // center sits one row up and one column left
    if (row_pos >= 2 && col_pos >= 2 && held_match) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          ref_pix = (dx == 0) ? col_prev2[dy] : ((dx == 1) ? col_prev[dy] : fresh[dy]);
          diff = (held_cur > ref_pix) ? held_cur - ref_pix : ref_pix - held_cur;
          total = {1'b0, sad_acc[dy*3+dx]} + diff;
          sad_acc[dy*3+dx] = total[SUM_W] ? '1 : total[SUM_W-1:0];
        end
      end
    end

    // shift window, load line buffers
    for (int r = 0; r < 3; r++) begin
      col_prev2[r] = col_prev[r];
      col_prev[r] = fresh[r];
    end
    held_cur = cur_one_above[col];
    held_match = match_one_above[col];
    bg_two_above[col] = bg_one_above[col];
    bg_one_above[col] = bg;
    cur_one_above[col] = cur;
    match_one_above[col] = match_now;

    row_end = (col_pos + 1 >= eff_w);
    frame_end = row_end && (row_pos + 1 >= eff_h);
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end

    if (frame_end) begin
      for (int k = 0; k < OFFSETS; k++) begin
        res.offset = k[OFF_W-1:0];
        res.sad = sad_acc[k];
        res.last = (k == OFFSETS - 1);
        expected_sums.push_back(res);
        sad_acc[k] = '0;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    sad_result_t want;
    if (!rst_n) begin
      frame_width = 13'd4096;
      frame_height = 13'd4096;
      match_index = '0;
      mask_enable = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        bg_two_above[i] = '0;
        bg_one_above[i] = '0;
        cur_one_above[i] = '0;
        match_one_above[i] = 1'b0;
      end
      for (int r = 0; r < 3; r++) begin
        col_prev[r] = '0;
        col_prev2[r] = '0;
      end
      held_cur = '0;
      held_match = 1'b0;
      col_pos = 0;
      row_pos = 0;
      for (int k = 0; k < OFFSETS; k++) sad_acc[k] = '0;
      expected_sums.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width = cfg_data;
          REG_FRAME_HEIGHT: frame_height = cfg_data;
          REG_MATCH_INDEX:  match_index = cfg_data[PIX_W-1:0];
          REG_MASK_ENABLE:  mask_enable = cfg_data[0];
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        accumulate_pixel(in_current_pixel, in_background_pixel, in_mask_pixel);

      // compare each sum item with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected sum item: offset %0d sum %0d last %0b",
                     out_offset_index, out_sad_sum, out_last);
        end else begin
          want = expected_sums.pop_front();
          if (out_offset_index !== want.offset || out_sad_sum !== want.sad ||
              out_last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("sum mismatch: expected offset %0d sum %0d last %0b, got %0d %0d %0b",
                       want.offset, want.sad, want.last,
                       out_offset_index, out_sad_sum, out_last);
          end
        end
      end
    end
    mismatch_count <= errors;
    sums_pending <= expected_sums.size();
  end

endmodule

### sim/masked_sad_3x3_shift_sums_tb.sv
module masked_sad_3x3_shift_sums_tb;
  import msad_pkg::*;

  localparam int MAX_WIDTH     = 4096;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 140;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] in_current_pixel = '0;
  logic [PIX_W-1:0] in_background_pixel = '0;
  logic [PIX_W-1:0] in_mask_pixel = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OFF_W-1:0] out_offset_index;
  logic [SUM_W-1:0] out_sad_sum;
  logic             out_last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  reg_idx_t         cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  int          mismatch_count;
  int          sums_pending;
  bit          no_idle = 1'b0;
  int          ready_hold = 0;
  int unsigned cycle_count = 0;

  masked_sad_3x3_shift_sums #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_current_pixel    (in_current_pixel),
    .in_background_pixel (in_background_pixel),
    .in_mask_pixel       (in_mask_pixel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_offset_index    (out_offset_index),
    .out_sad_sum         (out_sad_sum),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  masked_sad_3x3_shift_sums_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_current_pixel    (in_current_pixel),
    .in_background_pixel (in_background_pixel),
    .in_mask_pixel       (in_mask_pixel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_offset_index    (out_offset_index),
    .out_sad_sum         (out_sad_sum),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .sums_pending        (sums_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL masked_sad_3x3_shift_sums");
      $finish;
    end
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int frame_pixels(int w, int h);
    int eff_w;
    int eff_h;
    eff_w = (w < 3) ? 3 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    eff_h = (h < 3) ? 3 : h;
    return eff_w * eff_h;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      ready_hold <= pick_gap();
    end
  end

  // one pixel item; valid stays high into the next item when there is no gap
  task automatic send_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] bg,
                            input logic [PIX_W-1:0] msk);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_current_pixel <= cur;
    in_background_pixel <= bg;
    in_mask_pixel <= msk;
    do @(posedge clk); while (!in_ready);
  endtask

  // random pixels, mask mostly hitting the match value when masking is on
  task automatic send_frame(input int pixels, input logic [PIX_W-1:0] match, input bit masked);
    logic [PIX_W-1:0] msk;
    for (int i = 0; i < pixels; i++) begin
      msk = (masked && $urandom_range(0, 9) < 7) ? match : 8'($urandom_range(0, 255));
      send_pixel(pick_pixel(), pick_pixel(), msk);
    end
  endtask

  // sender holds off until every sum is out and the pipeline has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sums_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [PIX_W-1:0] match, input bit masked);
    reg_idx_t         order [4];
    logic [CFG_W-1:0] vals [4];
    order = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_MATCH_INDEX, REG_MASK_ENABLE};
    vals = '{w, h, CFG_W'(match), CFG_W'(masked)};
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int               sent;
    int               w;
    int               h;
    int               n_frames;
    logic [PIX_W-1:0] match;
    bit               masked;

    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // clamped 3x3 frame, masked, only the center pixel matches
    set_geometry(13'd0, 13'd2, 8'hff, 1'b1);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 2) ? 8'hff : 8'h00, (i % 2) ? 8'h00 : 8'hff,
                 (i == 4) ? 8'hff : 8'h00);
    // unmasked, mask byte ignored
    set_geometry(13'd1, 13'd1, 8'h00, 1'b0);
    for (int i = 0; i < 9; i++)
      send_pixel(8'hff - 8'(i * 31), 8'(i * 29), 8'h7f);

    // width shrinks mid-frame below the current column
    set_geometry(13'd8, 13'd4, 8'h3c, 1'b0);
    send_frame(13, 8'h3c, 1'b0);
    set_geometry(13'd4, 13'd4, 8'h3c, 1'b1);
    send_frame(9, 8'h3c, 1'b1);

    // height shrinks mid-frame below the current row
    set_geometry(13'd4, 13'd6, 8'h00, 1'b1);
    send_frame(14, 8'h00, 1'b1);
    set_geometry(13'd4, 13'd3, 8'h00, 1'b1);
    send_frame(2, 8'h00, 1'b1);

    // larger frame with no idling on either side
    no_idle = 1'b1;
    set_geometry(13'd10, 13'd5, 8'h00, 1'b0);
    send_frame(frame_pixels(10, 5), 8'h00, 1'b0);
    no_idle = 1'b0;

    // random small frames, some back to back under one setting
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0)
        match = $urandom_range(0, 1) ? 8'hff : 8'h00;
      else
        match = 8'($urandom_range(0, 255));
      masked = $urandom_range(0, 1);
      set_geometry(CFG_W'(w), CFG_W'(h), match, masked);
      n_frames = $urandom_range(1, 3);
      repeat (n_frames) begin
        send_frame(frame_pixels(w, h), match, masked);
        sent += frame_pixels(w, h);
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("PASS masked_sad_3x3_shift_sums");
    else
      $display("FAIL masked_sad_3x3_shift_sums");
    $finish;
  end

endmodule
